### rtl/epp_timer_pkg.sv
// Package for the eased playback phase timer: payload structs, request codes,
// register indexes and sequencer states. No dependencies.
`default_nettype none
package epp_timer_pkg;

  localparam int unsigned DurW   = 24;
  localparam int unsigned OffW   = 17;
  localparam int unsigned PhaseW = 17;
  localparam int unsigned DeltaW = 16;
  localparam int unsigned CfgW   = 24;
  localparam int unsigned AccW   = 48;
  localparam logic [16:0] Q16One = 17'h10000;

  typedef enum logic [2:0] {
    REQ_TICK    = 3'd0,
    REQ_START   = 3'd1,
    REQ_PLAY    = 3'd2,
    REQ_PAUSE   = 3'd3,
    REQ_RESTART = 3'd4,
    REQ_STOP    = 3'd5
  } req_e;

  typedef enum logic [2:0] {
    CFG_DURATION  = 3'd0,
    CFG_START_OFF = 3'd1,
    CFG_LOOP      = 3'd2,
    CFG_PING_PONG = 3'd3,
    CFG_REV_START = 3'd4,
    CFG_SEAMLESS  = 3'd5,
    CFG_EASING    = 3'd6,
    CFG_PLAY_ON   = 3'd7
  } cfg_e;

  typedef enum logic [1:0] {
    EASE_LINEAR = 2'd0,
    EASE_SMOOTH = 2'd1,
    EASE_SMOOTHER = 2'd2
  } ease_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RST_MUL,
    ST_RST_FIN,
    ST_TICK,
    ST_FOLD_DIV,
    ST_FOLD_FIN,
    ST_PH_DIV,
    ST_PH_SAT,
    ST_EA_MUL,
    ST_EA_NEXT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [DeltaW-1:0] delta;
  } req_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [DurW-1:0]   time_now;
    logic              backward;
    logic              playing;
    logic              finished;
  } rsp_t;

endpackage
`default_nettype wire

### rtl/eased_playback_phase_timer_top.sv
// Eased playback phase timer top level: state machine, serial multiplier
// and serial divider sharing one step counter. Uses epp_timer_pkg.
// Steps: a start or restart first forms the restart product, a running tick may first
// fold the time with a division; then phase division, saturate, easing products
// (smoothstep or smootherstep) and output; a stalled result adds its wait.
// A new request is taken only once the previous one has reached the output; a waiting result does not block input.
// Reset clears the state and loads the register reset values.
`default_nettype none
module eased_playback_phase_timer_top
  import epp_timer_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire req_t       in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output rsp_t            out_data_o,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i
);

  logic [DurW-1:0] dur_q;
  logic [OffW-1:0] off_q;
  logic loop_q, pp_q, rev_q, seam_q, pos_q;
  logic [1:0] ease_q;

  logic [DurW-1:0] time_q, time_d;
  logic dir_q, dir_d, run_q, run_d, done_q, done_d;

  state_e state_q, state_d;
  // shared datapath
  logic [AccW-1:0] acc_q, acc_d;     // product
  logic [AccW-1:0] mc_q, mc_d;       // multiplicand
  logic [25:0]     dv_q, dv_d;       // divisor
  logic [5:0]      cnt_q, cnt_d;
  logic [16:0]     x_q, x_d, t2_q, t2_d;
  logic [1:0]      step_q, step_d;
  logic [25:0]     rem_q, rem_d;
  logic [41:0]     quo_q, quo_d;
  logic [25:0]     tmp_q, tmp_d;     // signed-ish time after tick
  logic            neg_q, neg_d;
  logic [PhaseW-1:0] ph_q, ph_d;
  rsp_t            out_q, out_d;
  logic            ov_q, ov_d;
  req_t            req_q, req_d;

  logic [DurW-1:0] deff;
  assign deff = (dur_q == '0) ? DurW'(1) : dur_q;

  logic [16:0] off_sat;
  assign off_sat = (off_q > Q16One) ? Q16One : off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DurW'(1000); off_q <= '0; loop_q <= 1'b0; pp_q <= 1'b0;
      rev_q <= 1'b0; seam_q <= 1'b0; ease_q <= EASE_LINEAR; pos_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_e'(cfg_idx_i))
        CFG_DURATION:  dur_q  <= cfg_data_i;
        CFG_START_OFF: off_q  <= cfg_data_i[OffW-1:0];
        CFG_LOOP:      loop_q <= cfg_data_i[0];
        CFG_PING_PONG: pp_q   <= cfg_data_i[0];
        CFG_REV_START: rev_q  <= cfg_data_i[0];
        CFG_SEAMLESS:  seam_q <= cfg_data_i[0];
        CFG_EASING:    ease_q <= cfg_data_i[1:0];
        CFG_PLAY_ON:   pos_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_valid_o = ov_q;
  assign out_data_o = out_q;

  // restoring divide step helper
  logic [26:0] trial;
  logic [DurW:0] twod;
  logic [25:0] smag;
  logic [35:0] pval;
  logic [16:0] lin_sat;

  always_comb begin
    state_d = state_q; time_d = time_q; dir_d = dir_q; run_d = run_q; done_d = done_q;
    acc_d = acc_q; mc_d = mc_q; dv_d = dv_q; cnt_d = cnt_q; x_d = x_q; t2_d = t2_q;
    step_d = step_q; rem_d = rem_q; quo_d = quo_q; tmp_d = tmp_q; neg_d = neg_q;
    ph_d = ph_q; out_d = out_q; ov_d = ov_q; req_d = req_q;
    trial = '0; twod = {deff, 1'b0}; smag = '0; pval = '0;
    lin_sat = '0;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          req_d = in_data_i;
          case (in_data_i.req_type)
            REQ_TICK: state_d = run_q ? ST_TICK : ST_PH_DIV;
            REQ_START, REQ_RESTART: state_d = ST_RST_MUL;
            REQ_PLAY: begin
              run_d = 1'b1;
              state_d = done_q ? ST_RST_MUL : ST_PH_DIV;
            end
            REQ_PAUSE: begin run_d = 1'b0; state_d = ST_PH_DIV; end
            REQ_STOP: begin run_d = 1'b0; done_d = 1'b1; state_d = ST_PH_DIV; end
            default: state_d = ST_PH_DIV;
          endcase
          acc_d = '0;
          mc_d = AccW'(deff);
          x_d = rev_q ? Q16One - off_sat : off_sat;
          cnt_d = (state_d == ST_RST_MUL) ? 6'd17 : 6'd0;
          quo_d = '0; rem_d = '0;
        end
      end
      // shift-add: acc += mc when multiplier lsb set; multiplier in x_q
      ST_RST_MUL: begin
        if (x_q[0]) acc_d = acc_q + mc_q;
        else acc_d = acc_q;
        mc_d = {mc_q[AccW-2:0], 1'b0};
        x_d = {1'b0, x_q[16:1]};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = ST_RST_FIN;
      end
      ST_RST_FIN: begin
        time_d = acc_q[16 +: DurW];
        dir_d = rev_q; done_d = 1'b0;
        run_d = (req_q.req_type == REQ_START) ? pos_q : 1'b1;
        state_d = ST_PH_DIV;
      end
      ST_TICK: begin
        if (dir_q) begin
          neg_d = {10'd0, req_q.delta} > {2'b0, time_q};
          tmp_d = neg_d ? 26'({10'd0, req_q.delta} - {2'b0, time_q})
                        : 26'({2'b0, time_q} - {10'd0, req_q.delta});
        end else begin
          neg_d = 1'b0;
          tmp_d = 26'({2'b0, time_q} + {10'd0, req_q.delta});
        end
        state_d = ST_PH_DIV;
        if (loop_q) begin
          if (pp_q) begin
            if (neg_d || tmp_d > {2'b0, deff}) begin
              dv_d = {1'b0, twod}; rem_d = '0; quo_d = 42'(tmp_d);
              cnt_d = 6'd26; state_d = ST_FOLD_DIV;
            end else time_d = tmp_d[DurW-1:0];
          end else begin
            dv_d = {2'b0, deff}; rem_d = '0; quo_d = 42'(tmp_d);
            cnt_d = 6'd26; state_d = ST_FOLD_DIV;
          end
        end else if (neg_d || tmp_d == '0 || tmp_d >= {2'b0, deff}) begin
          time_d = neg_d ? '0 : (tmp_d > {2'b0, deff} ? deff : tmp_d[DurW-1:0]);
          run_d = 1'b0; done_d = 1'b1;
        end else time_d = tmp_d[DurW-1:0];
      end
      ST_FOLD_DIV: begin
        trial = {rem_q, quo_q[25]};
        quo_d = {quo_q[40:0], 1'b0};
        if (trial >= {1'b0, dv_q}) rem_d = 26'(trial - {1'b0, dv_q});
        else rem_d = trial[25:0];
        quo_d[25:0] = {quo_q[24:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = ST_FOLD_FIN;
      end
      ST_FOLD_FIN: begin
        smag = rem_q;
        if (pp_q) begin
          if (smag == '0) begin time_d = '0; dir_d = 1'b1; end
          else if (smag <= {2'b0, deff}) begin time_d = smag[DurW-1:0]; dir_d = 1'b0; end
          else begin time_d = 24'({1'b0, twod} - smag); dir_d = 1'b1; end
        end else begin
          time_d = (neg_q && smag != '0) ? 24'({2'b0, deff} - smag) : smag[DurW-1:0];
        end
        state_d = ST_PH_DIV;
        rem_d = '0; quo_d = '0; cnt_d = '0;
      end
      // phase: (time << 16) / D, 40-bit dividend, one quotient bit per cycle
      ST_PH_DIV: begin
        if (cnt_q == 6'd0 && quo_q == '0 && rem_q == '0) begin
          quo_d = {2'b0, time_q, 16'd0}; dv_d = {2'b0, deff}; cnt_d = 6'd40;
        end else begin
          trial = {rem_q, quo_q[39]};
          quo_d = {quo_q[40:0], 1'b0};
          if (trial >= {1'b0, dv_q}) begin
            rem_d = 26'(trial - {1'b0, dv_q}); quo_d[0] = 1'b1;
          end else rem_d = trial[25:0];
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_d = ST_PH_SAT;
        end
      end
      ST_PH_SAT: begin
        lin_sat = (quo_q[39:0] > 40'(Q16One)) ? Q16One : quo_q[16:0];
        x_d = lin_sat;
        rem_d = '0; quo_d = '0; cnt_d = '0;
        if ((loop_q && !pp_q && seam_q) ||
            (ease_q != EASE_SMOOTH && ease_q != EASE_SMOOTHER)) begin
          ph_d = lin_sat; state_d = ST_OUT;
        end else begin
          // first product x*x
          acc_d = '0; mc_d = AccW'(lin_sat); t2_d = lin_sat; cnt_d = 6'd17;
          step_d = 2'd0; state_d = ST_EA_MUL;
        end
      end
      ST_EA_MUL: begin
        if (t2_q[0]) acc_d = acc_q + mc_q;
        mc_d = {mc_q[AccW-2:0], 1'b0};
        t2_d = {1'b0, t2_q[16:1]};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) state_d = ST_EA_NEXT;
      end
      ST_EA_NEXT: begin
        state_d = ST_EA_MUL; cnt_d = 6'd18;
        if (ease_q == EASE_SMOOTH) begin
          // step 0: acc=x*x; then multiply by (196608-2x) (18 bits) >> 32
          if (step_q == 2'd0) begin
            mc_d = acc_q; acc_d = '0;
            pval = 36'(18'(196608) - {x_q, 1'b0});
            t2_d = pval[16:0]; tmp_d = 26'(pval[17]); step_d = 2'd1;
            cnt_d = 6'd17;
          end else if (step_q == 2'd1) begin
            // remaining top bit of multiplier
            acc_d = tmp_q[0] ? acc_q + {mc_q[AccW-1:0]} : acc_q;
            state_d = ST_OUT;
            ph_d = (x_q == Q16One) ? Q16One : {1'b0, acc_d[AccW-1:32]};
          end
        end else begin
          // smootherstep: step0 x2=x*x>>16; step1 x3=x2*x>>16; step2 x3*p>>16
          if (step_q == 2'd0) begin
            t2_d = x_q; mc_d = AccW'(acc_q[32:16]); tmp_d = 26'(acc_q[32:16]);
            acc_d = '0; step_d = 2'd1; cnt_d = 6'd17;
          end else if (step_q == 2'd1) begin
            pval = 36'({tmp_q[16:0], 2'b0} + {tmp_q[16:0], 1'b0}) + 36'd655360
                   - 36'({x_q, 4'b0} - x_q);
            mc_d = AccW'(acc_q[32:16]); acc_d = '0;
            t2_d = pval[16:0]; tmp_d = 26'(pval[19:17]);
            step_d = 2'd2; cnt_d = 6'd17;
          end else begin
            acc_d = acc_q + (tmp_q[0] ? mc_q : '0)
                    + (tmp_q[1] ? {mc_q[AccW-2:0], 1'b0} : '0)
                    + (tmp_q[2] ? {mc_q[AccW-3:0], 2'b0} : '0);
            state_d = ST_OUT;
            ph_d = (acc_d[AccW-1:16] > 32'(Q16One)) ? Q16One : acc_d[32:16];
          end
        end
      end
      ST_OUT: begin
        if (!ov_q || !out_stall_i) begin
          out_d.phase = ph_q;
          out_d.time_now = time_q; out_d.backward = dir_q;
          out_d.playing = run_q; out_d.finished = done_q;
          ov_d = 1'b1; state_d = ST_IDLE;
          acc_d = '0; quo_d = '0; rem_d = '0; cnt_d = '0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; time_q <= '0; dir_q <= 1'b0; run_q <= 1'b0; done_q <= 1'b0;
      ov_q <= 1'b0; cnt_q <= '0; quo_q <= '0; rem_q <= '0;
    end else begin
      state_q <= state_d; time_q <= time_d; dir_q <= dir_d; run_q <= run_d;
      done_q <= done_d; ov_q <= ov_d; cnt_q <= cnt_d; quo_q <= quo_d; rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d; mc_q <= mc_d; dv_q <= dv_d; x_q <= x_d; t2_q <= t2_d;
    step_q <= step_d; tmp_q <= tmp_d; neg_q <= neg_d; ph_q <= ph_d;
    out_q <= out_d; req_q <= req_d;
  end

endmodule
`default_nettype wire

### test/tb.sv
// Testbench for eased_playback_phase_timer_top: drives requests and register writes,
// predicts each response from its own playback model and checks it.
// Depends on epp_timer_pkg and the RTL top level.
`default_nettype none
module tb;
  import epp_timer_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_data = '0;

  eased_playback_phase_timer_top i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // timer state and registers as predicted
  logic [23:0] m_dur;
  logic [16:0] m_off;
  logic m_loop, m_pp, m_rev, m_seam, m_play_on;
  logic [1:0] m_ease;
  logic [23:0] m_time;
  logic m_back, m_run, m_done;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_send = 1'b0;
  bit in_taken = 1'b0;

  function automatic longint eff_dur();
    return (m_dur == 0) ? 64'd1 : longint'(m_dur);
  endfunction

  function automatic void restart_timer();
    longint off;
    off = (m_off > 17'h10000) ? 65536 : longint'(m_off);
    if (m_rev) off = 65536 - off;
    m_back = m_rev;
    m_time = 24'((off * eff_dur()) >> 16);
    m_done = 1'b0;
    m_run = 1'b1;
  endfunction

  function automatic void advance_time(logic [15:0] delta);
    longint d, t, s, m;
    d = eff_dur();
    t = longint'(m_time);
    if (!m_run) return;
    t = m_back ? t - longint'(delta) : t + longint'(delta);
    if (m_loop) begin
      if (m_pp) begin
        if (t < 0 || t > d) begin
          s = (t < 0) ? -t : t;
          m = s % (2 * d);
          if (m == 0) begin
            t = 0;
            m_back = 1'b1;
          end else if (m <= d) begin
            t = m;
            m_back = 1'b0;
          end else begin
            t = 2 * d - m;
            m_back = 1'b1;
          end
        end
      end else begin
        t = t % d;
        if (t < 0) t += d;
      end
    end else if (t >= d || t <= 0) begin
      if (t < 0) t = 0;
      if (t > d) t = d;
      m_run = 1'b0;
      m_done = 1'b1;
    end
    m_time = 24'(t);
  endfunction

  function automatic rsp_t playback_response(req_t r);
    rsp_t o;
    longint unsigned x, y, x2, x3;
    longint p;
    case (r.req_type)
      REQ_TICK: advance_time(r.delta);
      REQ_START: begin
        restart_timer();
        if (!m_play_on) m_run = 1'b0;
      end
      REQ_PLAY: begin
        if (m_done) restart_timer();
        m_run = 1'b1;
      end
      REQ_PAUSE: m_run = 1'b0;
      REQ_RESTART: restart_timer();
      REQ_STOP: begin
        m_run = 1'b0;
        m_done = 1'b1;
      end
      default: ;
    endcase
    x = (longint'(m_time) << 16) / eff_dur();
    if (x > 65536) x = 65536;
    if (m_loop && !m_pp && m_seam) y = x;
    else if (m_ease == EASE_SMOOTH) y = (x * x * (196608 - 2 * x)) >> 32;
    else if (m_ease == EASE_SMOOTHER) begin
      x2 = (x * x) >> 16;
      x3 = (x2 * x) >> 16;
      p = 6 * longint'(x2) - 15 * longint'(x) + 655360;
      if (p < 0) p = 0;
      y = (x3 * longint'(p)) >> 16;
    end else y = x;
    if (y > 65536) y = 65536;
    o.phase = 17'(y);
    o.time_now = m_time;
    o.backward = m_back;
    o.playing = m_run;
    o.finished = m_done;
    return o;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst_n && !hold_send && pending_reqs.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    rsp_t e;
    in_taken = in_valid && !in_stall;
    if (in_valid && !in_stall) expected_rsps.push_back(playback_response(in_data));
    if (out_valid && !out_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t unexpected transfer %h", $time, out_data);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (e.phase !== out_data.phase)
          $display("%0t phase exp %0d got %0d", $time, e.phase, out_data.phase);
        if (e.time_now !== out_data.time_now)
          $display("%0t time_now exp %0d got %0d", $time, e.time_now, out_data.time_now);
        if (e.backward !== out_data.backward)
          $display("%0t backward exp %0b got %0b", $time, e.backward, out_data.backward);
        if (e.playing !== out_data.playing)
          $display("%0t playing exp %0b got %0b", $time, e.playing, out_data.playing);
        if (e.finished !== out_data.finished)
          $display("%0t finished exp %0b got %0b", $time, e.finished, out_data.finished);
        if (e !== out_data) errors++;
      end
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(cfg_e idx, logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_DURATION: m_dur = val[23:0];
      CFG_START_OFF: m_off = val[16:0];
      CFG_LOOP: m_loop = val[0];
      CFG_PING_PONG: m_pp = val[0];
      CFG_REV_START: m_rev = val[0];
      CFG_SEAMLESS: m_seam = val[0];
      CFG_EASING: m_ease = val[1:0];
      default: m_play_on = val[0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_req(logic [2:0] kind, logic [15:0] delta);
    req_t r;
    r.req_type = kind;
    r.delta = delta;
    pending_reqs.push_back(r);
  endtask

  // durations mostly small so ticks cross the ends often
  function automatic logic [23:0] pick_duration();
    case ($urandom_range(5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 8));
      3: return 24'($urandom);
      default: return 24'($urandom_range(1, 200000));
    endcase
  endfunction

  task automatic random_setting(int extreme);
    write_reg(CFG_DURATION, extreme == 1 ? 24'hFFFFFF : extreme == 2 ? 24'd0 : pick_duration());
    write_reg(CFG_START_OFF, extreme == 1 ? 24'h1FFFF :
              24'($urandom_range(0, 3) == 0 ? 65536 : $urandom_range(0, 131071)));
    write_reg(CFG_LOOP, 24'($urandom_range(1)));
    write_reg(CFG_PING_PONG, 24'($urandom_range(1)));
    write_reg(CFG_REV_START, 24'($urandom_range(1)));
    write_reg(CFG_SEAMLESS, 24'($urandom_range(1)));
    write_reg(CFG_EASING, 24'($urandom_range(3)));
    write_reg(CFG_PLAY_ON, 24'($urandom_range(1)));
  endtask

  task automatic random_reqs(int n);
    logic [15:0] dl;
    repeat (n) begin
      case ($urandom_range(9))
        0: dl = 16'hFFFF;
        1: dl = 16'($urandom_range(0, 3));
        2: dl = 16'($urandom);
        default: dl = 16'($urandom_range(0, 300));
      endcase
      if ($urandom_range(99) < 70) add_req(REQ_TICK, dl);
      else add_req(3'($urandom_range(1, 7)), 16'($urandom));
    end
  endtask

  initial begin
    m_dur = 24'd1000; m_off = '0; m_loop = 0; m_pp = 0; m_rev = 0; m_seam = 0;
    m_ease = EASE_LINEAR; m_play_on = 1; m_time = '0; m_back = 0; m_run = 0; m_done = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed: every request kind, field extremes, end clamps
    add_req(REQ_TICK, 16'd5);
    add_req(REQ_START, 16'hFFFF);
    add_req(REQ_TICK, 16'd0);
    add_req(REQ_TICK, 16'd999);
    add_req(REQ_TICK, 16'hFFFF);
    add_req(REQ_PLAY, 16'd0);
    add_req(REQ_PAUSE, 16'd0);
    add_req(REQ_TICK, 16'd10);
    add_req(REQ_RESTART, 16'd0);
    add_req(REQ_STOP, 16'd0);
    add_req(3'd6, 16'hFFFF);
    add_req(3'd7, 16'd0);
    drain();
    write_reg(CFG_LOOP, 24'd1);
    write_reg(CFG_PING_PONG, 24'd1);
    write_reg(CFG_REV_START, 24'd1);
    write_reg(CFG_START_OFF, 24'h1FFFF);
    write_reg(CFG_EASING, 24'(EASE_SMOOTHER));
    write_reg(CFG_DURATION, 24'd0);
    add_req(REQ_START, 16'd0);
    add_req(REQ_TICK, 16'd1);
    add_req(REQ_TICK, 16'd2);
    add_req(REQ_TICK, 16'hFFFF);
    add_req(REQ_TICK, 16'd3);
    drain();
    write_reg(CFG_PLAY_ON, 24'd0);
    write_reg(CFG_SEAMLESS, 24'd1);
    write_reg(CFG_EASING, 24'd3);
    add_req(REQ_START, 16'd0);
    add_req(REQ_PLAY, 16'd0);
    add_req(REQ_TICK, 16'd7);
    drain();
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 79; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 79; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      random_setting(ph < 3 ? ph : 0);
      add_req(REQ_RESTART, 16'd0);
      random_reqs(52);
      if (ph == 5) begin
        while (pending_reqs.size() > 26) @(posedge clk);
        hold_send = 1'b1;
        while (in_valid || expected_rsps.size() > 0) @(posedge clk);
        hold_send = 1'b0;
      end
      random_reqs(52);
      drain();
    end
    send_idle_pct = 0;
    stall_pct = 0;
    drain();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
